[rtl/cfgf16_pkg.sv]
// ----------------------------------------------------------------------------
// cfgf16_pkg
// Types, codes and GF(16) / GF(256) helpers for the composite field ALU.
// ----------------------------------------------------------------------------
package cfgf16_pkg;

   localparam int MAP_ROWS    = 8;
   localparam int ROW_IDX_W   = $clog2(MAP_ROWS);
   localparam int CSR_ADDR_W  = ROW_IDX_W + 2;
   localparam int CSR_DATA_W  = 32;
   localparam int MAP_ROW_W   = 16;

   typedef logic [2:0]            kind_type;
   typedef logic [7:0]            byte_type;
   typedef logic [3:0]            nib_type;
   typedef logic [MAP_ROW_W-1:0]  map_row_type;

   localparam kind_type KIND_ADD     = 3'd0;
   localparam kind_type KIND_MUL     = 3'd1;
   localparam kind_type KIND_INV     = 3'd2;
   localparam kind_type KIND_MAP_FWD = 3'd3;
   localparam kind_type KIND_MAP_BWD = 3'd4;

   // x^4 + x^3 + 1
   localparam logic [4:0] FIELD_POLY = 5'h19;
   // z^2 = z + Z_CONST
   localparam nib_type    Z_CONST    = 4'h2;

   localparam map_row_type MAP_RESET [MAP_ROWS] = '{
      16'hAC68, 16'hDE24, 16'hD288, 16'h7CDC,
      16'h8C82, 16'h92E2, 16'hA4B0, 16'h9937
   };

   localparam nib_type NIB_INV_TABLE [16] = '{
      4'h0, 4'h1, 4'hC, 4'h8, 4'h6, 4'hF, 4'h4, 4'hE,
      4'h3, 4'hD, 4'hB, 4'hA, 4'h2, 4'h9, 4'h7, 4'h5
   };

   typedef struct packed {
      kind_type kind;
      byte_type operand_a;
      byte_type operand_b;
   } req_word_type;

   typedef struct packed {
      byte_type result;
   } rsp_word_type;

   // Shift-and-add multiply in GF(16)
   function automatic nib_type nib_mul(nib_type p, nib_type q);
      logic [4:0] a;
      nib_type    acc;
      a   = {1'b0, p};
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         if (q[k]) acc = acc ^ a[3:0];
         a = {a[3:0], 1'b0};
         if (a[4]) a = a ^ FIELD_POLY;
      end
      return acc;
   endfunction

   // (b z + c)(d z + e) = (be + cd + bd) z + (ce + 2bd)
   function automatic byte_type byte_mul(byte_type x, byte_type y);
      nib_type hh;
      nib_type hi;
      nib_type lo;
      hh = nib_mul(x[7:4], y[7:4]);
      hi = nib_mul(x[3:0], y[7:4]) ^ nib_mul(x[7:4], y[3:0]) ^ hh;
      lo = nib_mul(x[3:0], y[3:0]) ^ nib_mul(hh, Z_CONST);
      return {hi, lo};
   endfunction

   // delta = bc + c^2 + 2b^2; inverse of zero comes out as zero
   function automatic byte_type byte_inv(byte_type x);
      nib_type b;
      nib_type c;
      nib_type delta;
      nib_type di;
      b     = x[7:4];
      c     = x[3:0];
      delta = nib_mul(b, c) ^ nib_mul(c, c) ^ nib_mul(Z_CONST, nib_mul(b, b));
      di    = NIB_INV_TABLE[delta];
      return {nib_mul(di, b), nib_mul(di, b ^ c)};
   endfunction

endpackage

[rtl/cfgf16_req_if.sv]
// ----------------------------------------------------------------------------
// cfgf16_req_if
// Valid/ready channel carrying one operation word into the ALU.
// ----------------------------------------------------------------------------
interface cfgf16_req_if;
   import cfgf16_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);

endinterface

[rtl/cfgf16_rsp_if.sv]
// ----------------------------------------------------------------------------
// cfgf16_rsp_if
// Valid/ready channel carrying one result word out of the ALU.
// ----------------------------------------------------------------------------
interface cfgf16_rsp_if;
   import cfgf16_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);

endinterface

[rtl/composite_field_gf16_squared_alu_unit.sv]
// ----------------------------------------------------------------------------
// composite_field_gf16_squared_alu_unit
// GF((2^4)^2) arithmetic unit: one operation word in, one result word out.
//
// Takes one word per clock unless stalled and returns one result word per
// word, in order. A word is taken into the input register, the field logic
// settles between that register and the result register, and the result
// is offered from the result register. Both registers are elastic: the
// input side keeps taking words while a result waits, and stalls only
// once both stages are full. Kinds: 0 add (XOR), 1 multiply, 2 inverse
// (inverse of zero is zero), 3 basis map into the composite field,
// 4 basis map back; kinds 5..7 return zero. GF(16) is reduced by
// x^4+x^3+1 and a byte b:c means b*z+c with z^2 = z+2. The eight map rows
// are 16-bit APB registers at byte addresses 0x00..0x1C (step 4); the high
// byte of a row is the forward row, the low byte the backward row, and
// bit 7-i of a mapped byte is the parity of the operand ANDed with row i.
// Rows are to be written only while the unit is idle; the block itself
// does not enforce this. Reads return the row.
// ----------------------------------------------------------------------------
module composite_field_gf16_squared_alu_unit (
   input  logic                               clock,
   input  logic                               reset,
   cfgf16_req_if.sink                         req_word,
   cfgf16_rsp_if.source                       rsp_word,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cfgf16_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cfgf16_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cfgf16_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                               pready
);
   import cfgf16_pkg::*;

   // map row registers
   map_row_type              map_row_ff [MAP_ROWS];
   logic                     csr_write;
   logic [ROW_IDX_W-1:0]     csr_row;

   // input stage
   logic      s1_valid_ff, s1_valid_in;
   kind_type  s1_kind_ff,  s1_kind_in;
   byte_type  s1_a_ff,     s1_a_in;
   byte_type  s1_b_ff,     s1_b_in;

   // result stage
   logic      s2_valid_ff, s2_valid_in;
   byte_type  s2_result_ff, s2_result_in;

   logic      s1_ready;
   logic      s2_ready;
   logic      s1_load;
   logic      s2_load;

   byte_type  map_fwd;
   byte_type  map_bwd;
   byte_type  alu_result;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_row   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;
   assign prdata    = {{(CSR_DATA_W-MAP_ROW_W){1'b0}}, map_row_ff[csr_row]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_ROWS; i++) map_row_ff[i] <= MAP_RESET[i];
      end else if (csr_write) begin
         map_row_ff[csr_row] <= pwdata[MAP_ROW_W-1:0];
      end
   end

   // ---------------- handshake ----------------
   // result stage frees when empty or drained this cycle
   assign s2_ready = !s2_valid_ff || rsp_word.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s1_load  = req_word.valid && s1_ready;
   assign s2_load  = s1_valid_ff && s2_ready;

   assign req_word.ready       = s1_ready;
   assign rsp_word.valid       = s2_valid_ff;
   assign rsp_word.word.result = s2_result_ff;

   // ---------------- field datapath ----------------
   always_comb begin
      for (int i = 0; i < MAP_ROWS; i++) begin
         map_fwd[MAP_ROWS-1-i] = ^(s1_a_ff & map_row_ff[i][15:8]);
         map_bwd[MAP_ROWS-1-i] = ^(s1_a_ff & map_row_ff[i][7:0]);
      end
   end

   always_comb begin
      case (s1_kind_ff)
         KIND_ADD:     alu_result = s1_a_ff ^ s1_b_ff;
         KIND_MUL:     alu_result = byte_mul(s1_a_ff, s1_b_ff);
         KIND_INV:     alu_result = byte_inv(s1_a_ff);
         KIND_MAP_FWD: alu_result = map_fwd;
         KIND_MAP_BWD: alu_result = map_bwd;
         default:      alu_result = '0;
      endcase
   end

   // ---------------- next values ----------------
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_kind_in   = s1_kind_ff;
      s1_a_in      = s1_a_ff;
      s1_b_in      = s1_b_ff;
      s2_valid_in  = s2_valid_ff;
      s2_result_in = s2_result_ff;

      if (s1_ready) begin
         s1_valid_in = req_word.valid;
      end
      if (s1_load) begin
         s1_kind_in = req_word.word.kind;
         s1_a_in    = req_word.word.operand_a;
         s1_b_in    = req_word.word.operand_b;
      end
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
      if (s2_load) begin
         s2_result_in = alu_result;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_kind_ff   <= s1_kind_in;
      s1_a_ff      <= s1_a_in;
      s1_b_ff      <= s1_b_in;
      s2_result_ff <= s2_result_in;
   end

endmodule

[tb/sv/composite_field_gf16_squared_alu_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// composite_field_gf16_squared_alu_unit_tb
// Self-checking bench for the GF((2^4)^2) ALU. Request words go in through a
// valid/ready channel with random gaps. A field-arithmetic predictor built
// into a small scoreboard works out each result, and each returned word is
// checked in order. The map rows are walked through several patterns over
// APB, and each row is read back after it is written.
// ----------------------------------------------------------------------------
module composite_field_gf16_squared_alu_unit_tb;
   import cfgf16_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int MAX_GAP         = 17;
   localparam int PHASE_WORDS     = 290;
   // receiver stops taking results for a long while once, so both stages fill
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 300;
   // worst quiet stretch in a correct run is the hold-off above plus a few
   // gaps of MAX_GAP; this is several times that
   localparam int IDLE_LIMIT      = 3000;
   // room after the last result for a stray late word
   localparam int DRAIN_CYCLES    = 8;

   // kinds that the block does not define, all of which give zero
   localparam kind_type KIND_UNUSED_LO  = 3'd5;
   localparam kind_type KIND_UNUSED_MID = 3'd6;
   localparam kind_type KIND_UNUSED_HI  = 3'd7;

   localparam kind_type ALL_KINDS [8] = '{
      KIND_ADD, KIND_MUL, KIND_INV, KIND_MAP_FWD, KIND_MAP_BWD,
      KIND_UNUSED_LO, KIND_UNUSED_MID, KIND_UNUSED_HI
   };

   // corner words: operand extremes, every kind, inverse of zero, operand b
   // ignored by unary kinds, and the undefined kinds
   localparam req_word_type CORNER_WORDS [22] = '{
      {KIND_ADD,        8'h00, 8'h00},
      {KIND_ADD,        8'hFF, 8'hFF},
      {KIND_ADD,        8'hA5, 8'h5A},
      {KIND_MUL,        8'h00, 8'hFF},
      {KIND_MUL,        8'hFF, 8'hFF},
      {KIND_MUL,        8'h01, 8'hC3},
      {KIND_MUL,        8'h10, 8'h10},
      {KIND_MUL,        8'hFF, 8'h00},
      {KIND_INV,        8'h00, 8'hFF},
      {KIND_INV,        8'h01, 8'h00},
      {KIND_INV,        8'hFF, 8'h5A},
      {KIND_INV,        8'h10, 8'hFF},
      {KIND_MAP_FWD,    8'h00, 8'hFF},
      {KIND_MAP_FWD,    8'hFF, 8'h00},
      {KIND_MAP_FWD,    8'h80, 8'h3C},
      {KIND_MAP_FWD,    8'h01, 8'hC3},
      {KIND_MAP_BWD,    8'h00, 8'hFF},
      {KIND_MAP_BWD,    8'hFF, 8'h00},
      {KIND_MAP_BWD,    8'h01, 8'h81},
      {KIND_UNUSED_LO,  8'hFF, 8'hFF},
      {KIND_UNUSED_MID, 8'hA5, 8'h5A},
      {KIND_UNUSED_HI,  8'hFF, 8'h00}
   };

   typedef enum {ROWS_RANDOM, ROWS_ALL_ZERO, ROWS_ALL_ONE, ROWS_UNIT} row_pattern_type;

   typedef struct {
      req_word_type src;
      byte_type     result;
   } pending_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the map rows, the field predictor and the queue
   // of results still owed by the block.
   // -------------------------------------------------------------------------
   class gf_alu_scoreboard;
      map_row_type        rows [MAP_ROWS];
      pending_result_type awaited [$];
      int                 mismatches;

      function new();
         rows = '{16'hAC68, 16'hDE24, 16'hD288, 16'h7CDC,
                  16'h8C82, 16'h92E2, 16'hA4B0, 16'h9937};
         mismatches = 0;
      endfunction

      // GF(16) product, MSB-first with reduction on each shift
      function nib_type gf16_product(nib_type p, nib_type q);
         logic [4:0] acc;
         int         k;
         acc = '0;
         for (k = 3; k >= 0; k--) begin
            acc = {acc[3:0], 1'b0};
            if (acc[4]) acc = acc ^ FIELD_POLY;
            if (q[k]) acc[3:0] = acc[3:0] ^ p;
         end
         return acc[3:0];
      endfunction

      // found by search; zero has no inverse and maps to zero
      function nib_type gf16_reciprocal(nib_type x);
         nib_type found;
         int      y;
         found = '0;
         for (y = 1; y < 16; y++)
            if (gf16_product(x, nib_type'(y)) == 4'h1) found = nib_type'(y);
         return found;
      endfunction

      // (b z + c)(d z + e) with z^2 = z + 2
      function byte_type composite_product(byte_type x, byte_type y);
         nib_type bd;
         bd = gf16_product(x[7:4], y[7:4]);
         return {gf16_product(x[7:4], y[3:0]) ^ gf16_product(x[3:0], y[7:4]) ^ bd,
                 gf16_product(x[3:0], y[3:0]) ^ gf16_product(Z_CONST, bd)};
      endfunction

      function byte_type composite_inverse(byte_type x);
         nib_type hi;
         nib_type lo;
         nib_type norm;
         nib_type scale;
         hi    = x[7:4];
         lo    = x[3:0];
         norm  = gf16_product(hi, lo) ^ gf16_product(lo, lo)
               ^ gf16_product(Z_CONST, gf16_product(hi, hi));
         scale = gf16_reciprocal(norm);
         return {gf16_product(scale, hi), gf16_product(scale, hi ^ lo)};
      endfunction

      // bit 7-i is the parity of x masked by row byte i
      function byte_type basis_change(byte_type x, bit forward);
         byte_type mapped;
         byte_type row_byte;
         int       i;
         mapped = '0;
         for (i = 0; i < MAP_ROWS; i++) begin
            row_byte      = forward ? rows[i][15:8] : rows[i][7:0];
            mapped[7 - i] = ^(x & row_byte);
         end
         return mapped;
      endfunction

      function byte_type field_result(req_word_type w);
         case (w.kind)
            KIND_ADD:     return w.operand_a ^ w.operand_b;
            KIND_MUL:     return composite_product(w.operand_a, w.operand_b);
            KIND_INV:     return composite_inverse(w.operand_a);
            KIND_MAP_FWD: return basis_change(w.operand_a, 1'b1);
            KIND_MAP_BWD: return basis_change(w.operand_a, 1'b0);
            default:      return '0;
         endcase
      endfunction

      function void note_word(req_word_type w);
         pending_result_type entry;
         entry.src    = w;
         entry.result = field_result(w);
         awaited.push_back(entry);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(string detail);
         $display("%0t ns mismatch: %s", $time, detail);
         mismatches++;
      endtask

      task check_result(rsp_word_type got);
         pending_result_type entry;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result %02h with no word outstanding", got.result));
            return;
         end
         entry = awaited.pop_front();
         if (got.result !== entry.result)
            report_mismatch($sformatf("kind %0d a %02h b %02h: result %02h, expected %02h",
                                      entry.src.kind, entry.src.operand_a,
                                      entry.src.operand_b, got.result, entry.result));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cfgf16_req_if req_if ();
   cfgf16_rsp_if rsp_if ();

   gf_alu_scoreboard sb;

   composite_field_gf16_squared_alu_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_if),
      .rsp_word (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // operands lean on the all-zero and all-one bytes now and then
   function automatic byte_type random_operand();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly defined kinds, with a share of the undefined ones
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      pick        = $urandom_range(0, 99);
      w.kind      = (pick < 88) ? ALL_KINDS[pick % 5] : ALL_KINDS[5 + pick % 3];
      w.operand_a = random_operand();
      w.operand_b = random_operand();
      return w;
   endfunction

   // Offers one word after an optional gap and returns once it is taken.
   // Starts and ends on a falling edge; valid stays high across a zero gap.
   task automatic send_word(req_word_type w, bit steady);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.word  <= w;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      sb.note_word(w);
      @(negedge clock);
   endtask

   // runs of back-to-back words are mixed in with gappy stretches
   task automatic run_random(int count);
      bit steady;
      int n;
      steady = 1'b0;
      for (n = 0; n < count; n++) begin
         if (n % 48 == 0) steady = ($urandom_range(0, 3) == 0);
         send_word(random_word(), steady);
      end
   endtask

   // stop offering and wait until every owed result has come back
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // One APB transfer: setup, access, then one idle cycle so that the next
   // transfer never drives psel twice in the same step. Reads are checked
   // against the scoreboard's copy of the row.
   task automatic csr_access(int idx, bit is_write, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_ADDR_W'(4 * idx);
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!(psel && penable && pready));
      if (is_write)
         sb.rows[idx] = data[MAP_ROW_W-1:0];
      else if (prdata !== CSR_DATA_W'(sb.rows[idx]))
         sb.report_mismatch($sformatf("map row %0d read %08h, expected %04h",
                                      idx, prdata, sb.rows[idx]));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // rewrite every row to one pattern and read each one back
   task automatic configure(row_pattern_type pattern);
      logic [CSR_DATA_W-1:0] data;
      int                    i;
      for (i = 0; i < MAP_ROWS; i++) begin
         case (pattern)
            ROWS_ALL_ZERO: data = '0;
            ROWS_ALL_ONE:  data = '1;
            ROWS_UNIT:     data = {16'h0000, 8'h80 >> i, 8'h80 >> i};
            default:       data = $urandom();
         endcase
         csr_access(i, 1'b1, data);
         csr_access(i, 1'b0, '0);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls, occasional runs with ready held high, and
   // one long hold-off so the block backs up into the request channel.
   // -------------------------------------------------------------------------
   initial begin
      int results_seen;
      int stall;
      bit steady;
      rsp_if.ready = 1'b0;
      results_seen = 0;
      steady       = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (results_seen % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         stall = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (results_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         sb.check_result(rsp_if.word);
         results_seen++;
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: gives up after a long run of cycles with no traffic at all.
   // -------------------------------------------------------------------------
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("composite_field_gf16_squared_alu_unit regression: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence: reset, check reset rows, corner words, then random words
   // under each row pattern, with the rows rewritten only when idle.
   // -------------------------------------------------------------------------
   initial begin
      int i;
      sb           = new();
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.word  = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rows must come out of reset with their documented values
      for (i = 0; i < MAP_ROWS; i++) csr_access(i, 1'b0, '0);

      foreach (CORNER_WORDS[n]) send_word(CORNER_WORDS[n], 1'b0);
      run_random(PHASE_WORDS);

      settle();
      configure(ROWS_RANDOM);
      run_random(PHASE_WORDS);

      settle();
      configure(ROWS_ALL_ZERO);
      run_random(PHASE_WORDS);

      settle();
      configure(ROWS_ALL_ONE);
      run_random(PHASE_WORDS);

      // identity in both directions: mapped byte equals the operand
      settle();
      configure(ROWS_UNIT);
      run_random(PHASE_WORDS);

      settle();
      configure(ROWS_RANDOM);
      run_random(PHASE_WORDS);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0)
         $display("composite_field_gf16_squared_alu_unit regression: pass");
      else
         $display("composite_field_gf16_squared_alu_unit regression: fail");
      $finish;
   end

endmodule
